// ===== hw/rtl/mp2d_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// mp2d_pkg
// Shared constants, register codes and control types of the mean pooling
// stream.
// ============================================================================
package mp2d_pkg;

    // Defaults of the top-level parameters.
    localparam int DEF_MAX_MAP_COLS = 1024;
    localparam int DEF_MAX_KERNEL   = 8;
    localparam int DEF_SAMPLE_WIDTH = 16;

    // Map height is capped independently of the line store depth.
    localparam int MAP_ROWS_CAP = 1024;
    localparam int ROW_AW       = $clog2(MAP_ROWS_CAP);
    localparam int ROW_GW       = ROW_AW + 2;

    // Configuration register widths.
    localparam int KERNEL_W    = 4;
    localparam int MAP_DIM_W   = 11;
    localparam int RECIP_W     = 17;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 17;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_KERNEL_ROWS = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KERNEL_COLS = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAP_COLS    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAP_ROWS    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_AREA_RECIP  = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [KERNEL_W-1:0]  RST_KERNEL_ROWS = 4'd2;
    localparam logic [KERNEL_W-1:0]  RST_KERNEL_COLS = 4'd2;
    localparam logic [MAP_DIM_W-1:0] RST_MAP_COLS    = 11'd28;
    localparam logic [MAP_DIM_W-1:0] RST_MAP_ROWS    = 11'd28;
    localparam logic [RECIP_W-1:0]   RST_AREA_RECIP  = 17'd16384;

    // Q1.16 scale: 1.0 and the rounding offset.
    localparam logic [RECIP_W-1:0] RECIP_ONE  = 17'd65536;
    localparam int                 FRAC_BITS  = 16;
    localparam int                 ROUND_HALF = 32768;

    // Result queue depth (power of two).
    localparam int FIFO_DEPTH = 4;

    // Per-item control derived from the raster counters.
    typedef struct packed {
        logic in_region;
        logic first;
        logic last;
        logic row_end;
        logic map_end;
    } mp2d_tag_t;

    // Flags that travel with a result item.
    typedef struct packed {
        logic row_end;
        logic map_end;
    } mp2d_flags_t;

endpackage

// ===== hw/rtl/mean_pool_2d_stream.sv =====
`timescale 1ns / 1ps
// ============================================================================
// mean_pool_2d_stream
// Non-overlapping 2-D average pooling of a raster-order sample stream, with
// block sums kept in a line store of one entry per output column.
// ============================================================================
//
//  Channel  Handshake                   Payload
//  -------  --------------------------  ----------------------------------
//  sample   sample_valid/sample_ready   sample
//  result   result_valid/result_ready   mean_value, row_end, map_end
//  config   cfg_valid/cfg_ready         cfg_index, cfg_data
//
// One sample is accepted every cycle while sample_ready is high; the line store
// does one read and one write per cycle, and back-to-back samples of the same
// block are forwarded. Results reach the queue via the sum and product stages.
// sample_ready drops only while four results are queued or in flight.
// After reset the block is ready at once: no store clearing is needed,
// since the first sample of each block overwrites its entry.
// cfg_ready is always high; a geometry write restarts the current map.
//
module mean_pool_2d_stream #(
    parameter int MAX_MAP_COLS = mp2d_pkg::DEF_MAX_MAP_COLS,
    parameter int MAX_KERNEL   = mp2d_pkg::DEF_MAX_KERNEL,
    parameter int SAMPLE_WIDTH = mp2d_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               sample_valid,
    output logic                               sample_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]     sample,
    output logic                               result_valid,
    input  logic                               result_ready,
    output logic signed [SAMPLE_WIDTH-1:0]     mean_value,
    output logic                               row_end,
    output logic                               map_end,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mp2d_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [mp2d_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import mp2d_pkg::*;

    localparam int AW    = $clog2(MAX_MAP_COLS);
    localparam int SUM_W = SAMPLE_WIDTH + 2 * $clog2(MAX_KERNEL);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    logic                    accept;
    mp2d_tag_t               tag;
    logic [AW-1:0]           addr;
    logic [RECIP_W-1:0]      recip;
    logic                    sum_valid;
    logic signed [SUM_W-1:0] sum;
    mp2d_flags_t             sum_flags;
    logic                    push;
    logic signed [SAMPLE_WIDTH-1:0] mean;
    mp2d_flags_t             mean_flags;
    logic                    pop;
    mp2d_flags_t             head_flags;
    logic [CNT_W-1:0]        fifo_count;
    logic [CNT_W:0]          reserved;

    // Admit a sample only while the queue can take every result in flight.
    always_comb
    begin
        reserved     = (CNT_W + 1)'(fifo_count) + (CNT_W + 1)'(sum_valid) +
                       (CNT_W + 1)'(push);
        sample_ready = reserved < (CNT_W + 1)'(FIFO_DEPTH);
        accept       = sample_valid && sample_ready;
        pop          = result_valid && result_ready;
        row_end      = head_flags.row_end;
        map_end      = head_flags.map_end;
    end

    assign cfg_ready = 1'b1;

    mp2d_ctrl #(
        .MAX_MAP_COLS (MAX_MAP_COLS),
        .MAX_KERNEL   (MAX_KERNEL)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .tag       (tag),
        .addr      (addr),
        .recip     (recip)
    );

    mp2d_accum #(
        .MAX_MAP_COLS (MAX_MAP_COLS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .SUM_W        (SUM_W)
    ) u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .tag       (tag),
        .addr      (addr),
        .sample    (sample),
        .sum_valid (sum_valid),
        .sum       (sum),
        .sum_flags (sum_flags)
    );

    mp2d_scale #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .SUM_W        (SUM_W)
    ) u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .sum_valid  (sum_valid),
        .sum        (sum),
        .sum_flags  (sum_flags),
        .recip      (recip),
        .push       (push),
        .mean       (mean),
        .mean_flags (mean_flags)
    );

    mp2d_fifo #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_mean  (mean),
        .push_flags (mean_flags),
        .pop        (pop),
        .not_empty  (result_valid),
        .head_mean  (mean_value),
        .head_flags (head_flags),
        .count      (fifo_count)
    );

    // The queue never holds more than its depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        fifo_count <= CNT_W'(FIFO_DEPTH))
        else $error("result queue overfilled");

    // A result is never pushed into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |-> (fifo_count < CNT_W'(FIFO_DEPTH)))
        else $error("push into full result queue");

    // The last sample of a block inside the map yields a result pushed after the sum and product stages.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && tag.in_region && tag.last) |-> ##2 push)
        else $error("completed block produced no result");

    // The end of a map is always also the end of an output row.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && map_end) |-> row_end)
        else $error("map end without row end");

endmodule

// ===== hw/rtl/mp2d_ctrl.sv =====
`timescale 1ns / 1ps
// ============================================================================
// mp2d_ctrl
// Configuration registers and raster counters; tags every sample with its
// line store column and block position.
// ============================================================================
module mp2d_ctrl #(
    parameter int MAX_MAP_COLS = mp2d_pkg::DEF_MAX_MAP_COLS,
    parameter int MAX_KERNEL   = mp2d_pkg::DEF_MAX_KERNEL
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    input  logic [mp2d_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [mp2d_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               accept,
    output mp2d_pkg::mp2d_tag_t                tag,
    output logic [$clog2(MAX_MAP_COLS)-1:0]    addr,
    output logic [mp2d_pkg::RECIP_W-1:0]       recip
);
    import mp2d_pkg::*;

    localparam int AW  = $clog2(MAX_MAP_COLS);
    localparam int KCW = $clog2(MAX_KERNEL);
    localparam int GW  = $clog2(MAX_MAP_COLS + 1) + 2;
    localparam int WW  = (GW > ROW_GW) ? GW : ROW_GW;

    logic [KERNEL_W-1:0]  kernel_rows_reg;
    logic [KERNEL_W-1:0]  kernel_cols_reg;
    logic [MAP_DIM_W-1:0] map_cols_reg;
    logic [MAP_DIM_W-1:0] map_rows_reg;
    logic [RECIP_W-1:0]   area_recip_reg;

    logic [KCW-1:0]    col_in_win_reg, col_in_win_next;
    logic [AW-1:0]     window_col_reg, window_col_next;
    logic [AW-1:0]     input_col_reg, input_col_next;
    logic [KCW-1:0]    row_in_win_reg, row_in_win_next;
    logic [ROW_AW-1:0] input_row_reg, input_row_next;

    logic [WW-1:0] kr, kc, mc, mr;
    logic [WW-1:0] col_start, row_start;
    logic          col_fit, col_edge, row_fit, row_edge;
    logic          geom_write;

    // Clamp the geometry registers to their legal ranges.
    always_comb
    begin
        if (kernel_rows_reg == '0)
            kr = WW'(1);
        else if (WW'(kernel_rows_reg) > WW'(MAX_KERNEL))
            kr = WW'(MAX_KERNEL);
        else
            kr = WW'(kernel_rows_reg);

        if (kernel_cols_reg == '0)
            kc = WW'(1);
        else if (WW'(kernel_cols_reg) > WW'(MAX_KERNEL))
            kc = WW'(MAX_KERNEL);
        else
            kc = WW'(kernel_cols_reg);

        if (map_cols_reg == '0)
            mc = WW'(1);
        else if (WW'(map_cols_reg) > WW'(MAX_MAP_COLS))
            mc = WW'(MAX_MAP_COLS);
        else
            mc = WW'(map_cols_reg);

        if (map_rows_reg == '0)
            mr = WW'(1);
        else if (WW'(map_rows_reg) > WW'(MAP_ROWS_CAP))
            mr = WW'(MAP_ROWS_CAP);
        else
            mr = WW'(map_rows_reg);

        recip = (area_recip_reg > RECIP_ONE) ? RECIP_ONE : area_recip_reg;
    end

    // A block lies inside the map when its first column and row plus the
    // kernel size stay within the map; the last block of a row is the one
    // after which another block would not fit.
    always_comb
    begin
        col_start = WW'(input_col_reg) - WW'(col_in_win_reg);
        row_start = WW'(input_row_reg) - WW'(row_in_win_reg);
        col_fit   = (col_start + kc) <= mc;
        col_edge  = (col_start + (kc << 1)) > mc;
        row_fit   = (row_start + kr) <= mr;
        row_edge  = (row_start + (kr << 1)) > mr;

        tag.in_region = col_fit && row_fit;
        tag.first     = (col_in_win_reg == '0) && (row_in_win_reg == '0);
        tag.last      = (WW'(col_in_win_reg) == kc - WW'(1)) &&
                        (WW'(row_in_win_reg) == kr - WW'(1));
        tag.row_end   = col_edge;
        tag.map_end   = col_edge && row_edge;
        addr          = window_col_reg;
    end

    // Raster counter advance for one accepted item.
    always_comb
    begin
        col_in_win_next = col_in_win_reg;
        window_col_next = window_col_reg;
        input_col_next  = input_col_reg;
        row_in_win_next = row_in_win_reg;
        input_row_next  = input_row_reg;

        if (WW'(col_in_win_reg) + WW'(1) >= kc)
        begin
            col_in_win_next = '0;
            window_col_next = window_col_reg + AW'(1);
        end
        else
        begin
            col_in_win_next = col_in_win_reg + KCW'(1);
        end

        input_col_next = input_col_reg + AW'(1);
        if (WW'(input_col_reg) + WW'(1) >= mc)
        begin
            input_col_next  = '0;
            col_in_win_next = '0;
            window_col_next = '0;
            if (WW'(row_in_win_reg) + WW'(1) >= kr)
                row_in_win_next = '0;
            else
                row_in_win_next = row_in_win_reg + KCW'(1);
            input_row_next = input_row_reg + ROW_AW'(1);
            if (WW'(input_row_reg) + WW'(1) >= mr)
            begin
                row_in_win_next = '0;
                input_row_next  = '0;
            end
        end
    end

    assign geom_write = cfg_valid && (cfg_index == CFG_KERNEL_ROWS ||
                                      cfg_index == CFG_KERNEL_COLS ||
                                      cfg_index == CFG_MAP_COLS ||
                                      cfg_index == CFG_MAP_ROWS);

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_rows_reg <= RST_KERNEL_ROWS;
            kernel_cols_reg <= RST_KERNEL_COLS;
            map_cols_reg    <= RST_MAP_COLS;
            map_rows_reg    <= RST_MAP_ROWS;
            area_recip_reg  <= RST_AREA_RECIP;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_KERNEL_ROWS: kernel_rows_reg <= cfg_data[KERNEL_W-1:0];
                CFG_KERNEL_COLS: kernel_cols_reg <= cfg_data[KERNEL_W-1:0];
                CFG_MAP_COLS:    map_cols_reg    <= cfg_data[MAP_DIM_W-1:0];
                CFG_MAP_ROWS:    map_rows_reg    <= cfg_data[MAP_DIM_W-1:0];
                CFG_AREA_RECIP:  area_recip_reg  <= cfg_data[RECIP_W-1:0];
                default:         ;
            endcase
        end
    end

    // Raster counters; a geometry write restarts the map.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_in_win_reg <= '0;
            window_col_reg <= '0;
            input_col_reg  <= '0;
            row_in_win_reg <= '0;
            input_row_reg  <= '0;
        end
        else if (geom_write)
        begin
            col_in_win_reg <= '0;
            window_col_reg <= '0;
            input_col_reg  <= '0;
            row_in_win_reg <= '0;
            input_row_reg  <= '0;
        end
        else if (accept)
        begin
            col_in_win_reg <= col_in_win_next;
            window_col_reg <= window_col_next;
            input_col_reg  <= input_col_next;
            row_in_win_reg <= row_in_win_next;
            input_row_reg  <= input_row_next;
        end
    end

endmodule

// ===== hw/rtl/mp2d_accum.sv =====
`timescale 1ns / 1ps
// ============================================================================
// mp2d_accum
// Line store of running block sums: read at accept, add the sample in the next
// cycle and write back, with forwarding of the previous write.
// ============================================================================
module mp2d_accum #(
    parameter int MAX_MAP_COLS = mp2d_pkg::DEF_MAX_MAP_COLS,
    parameter int SAMPLE_WIDTH = mp2d_pkg::DEF_SAMPLE_WIDTH,
    parameter int SUM_W        = 22
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               accept,
    input  mp2d_pkg::mp2d_tag_t                tag,
    input  logic [$clog2(MAX_MAP_COLS)-1:0]    addr,
    input  logic signed [SAMPLE_WIDTH-1:0]     sample,
    output logic                               sum_valid,
    output logic signed [SUM_W-1:0]            sum,
    output mp2d_pkg::mp2d_flags_t              sum_flags
);
    import mp2d_pkg::*;

    localparam int AW = $clog2(MAX_MAP_COLS);

    logic signed [SUM_W-1:0] store_mem [MAX_MAP_COLS];
    logic signed [SUM_W-1:0] rd_data_reg;

    logic                           s1_valid_reg;
    logic [AW-1:0]                  s1_addr_reg;
    logic                           s1_first_reg;
    logic                           s1_last_reg;
    mp2d_flags_t                    s1_flags_reg;
    logic signed [SAMPLE_WIDTH-1:0] s1_sample_reg;

    logic                    fwd_valid_reg;
    logic [AW-1:0]           fwd_addr_reg;
    logic signed [SUM_W-1:0] fwd_data_reg;

    logic signed [SUM_W-1:0] base;
    logic signed [SUM_W-1:0] sample_ext;

    // Read-modify-write stage: the read issued at accept returns the value
    // before the write of the same edge, so that write is forwarded.
    always_comb
    begin
        sample_ext = SUM_W'(s1_sample_reg);
        if (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg))
            base = fwd_data_reg;
        else
            base = rd_data_reg;
        sum = s1_first_reg ? sample_ext : (base + sample_ext);
    end

    assign sum_valid = s1_valid_reg && s1_last_reg;
    assign sum_flags = s1_flags_reg;

    // Line store with a registered read port.
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
            store_mem[s1_addr_reg] <= sum;
        if (accept)
            rd_data_reg <= store_mem[addr];
    end

    // Stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= accept && tag.in_region;
            fwd_valid_reg <= s1_valid_reg;
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_addr_reg          <= addr;
            s1_first_reg         <= tag.first;
            s1_last_reg          <= tag.last;
            s1_flags_reg.row_end <= tag.row_end;
            s1_flags_reg.map_end <= tag.map_end;
            s1_sample_reg        <= sample;
        end
        fwd_addr_reg <= s1_addr_reg;
        fwd_data_reg <= sum;
    end

endmodule

// ===== hw/rtl/mp2d_scale.sv =====
`timescale 1ns / 1ps
// ============================================================================
// mp2d_scale
// Multiplies a finished block sum by the area reciprocal, then rounds half
// up and saturates to the sample range.
// ============================================================================
module mp2d_scale #(
    parameter int SAMPLE_WIDTH = mp2d_pkg::DEF_SAMPLE_WIDTH,
    parameter int SUM_W        = 22
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               sum_valid,
    input  logic signed [SUM_W-1:0]            sum,
    input  mp2d_pkg::mp2d_flags_t              sum_flags,
    input  logic [mp2d_pkg::RECIP_W-1:0]       recip,
    output logic                               push,
    output logic signed [SAMPLE_WIDTH-1:0]     mean,
    output mp2d_pkg::mp2d_flags_t              mean_flags
);
    import mp2d_pkg::*;

    localparam int PW = SUM_W + RECIP_W + 2;
    localparam logic signed [PW-1:0] SAT_HI =
        {{(PW - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
    localparam logic signed [PW-1:0] SAT_LO =
        {{(PW - SAMPLE_WIDTH + 1){1'b1}}, {(SAMPLE_WIDTH - 1){1'b0}}};

    logic                 s2_valid_reg;
    logic signed [PW-1:0] prod_reg;
    mp2d_flags_t          s2_flags_reg;

    logic signed [PW-1:0] sum_x, recip_x, prod_next;
    logic signed [PW-1:0] rounded, quot, sat;

    // Multiply stage.
    always_comb
    begin
        sum_x     = PW'(sum);
        recip_x   = {{(PW - RECIP_W){1'b0}}, recip};
        prod_next = sum_x * recip_x;
    end

    // Round half toward plus infinity, then saturate.
    always_comb
    begin
        rounded = prod_reg + PW'(ROUND_HALF);
        quot    = rounded >>> FRAC_BITS;
        if (quot > SAT_HI)
            sat = SAT_HI;
        else if (quot < SAT_LO)
            sat = SAT_LO;
        else
            sat = quot;
        mean = sat[SAMPLE_WIDTH-1:0];
    end

    assign push       = s2_valid_reg;
    assign mean_flags = s2_flags_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= sum_valid;
    end

    always_ff @(posedge clk)
    begin
        if (sum_valid)
        begin
            prod_reg     <= prod_next;
            s2_flags_reg <= sum_flags;
        end
    end

endmodule

// ===== hw/rtl/mp2d_fifo.sv =====
`timescale 1ns / 1ps
// ============================================================================
// mp2d_fifo
// Small result queue that decouples the pipeline from the output handshake.
// ============================================================================
module mp2d_fifo #(
    parameter int SAMPLE_WIDTH = mp2d_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        push,
    input  logic signed [SAMPLE_WIDTH-1:0]              push_mean,
    input  mp2d_pkg::mp2d_flags_t                       push_flags,
    input  logic                                        pop,
    output logic                                        not_empty,
    output logic signed [SAMPLE_WIDTH-1:0]              head_mean,
    output mp2d_pkg::mp2d_flags_t                       head_flags,
    output logic [$clog2(mp2d_pkg::FIFO_DEPTH+1)-1:0]   count
);
    import mp2d_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    logic signed [SAMPLE_WIDTH-1:0] mean_mem  [FIFO_DEPTH];
    mp2d_flags_t                    flags_mem [FIFO_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign not_empty  = (count_reg != '0);
    assign head_mean  = mean_mem[rd_ptr_reg];
    assign head_flags = flags_mem[rd_ptr_reg];
    assign count      = count_reg;

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mean_mem[wr_ptr_reg]  <= push_mean;
            flags_mem[wr_ptr_reg] <= push_flags;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule
